@@ rtl/pvh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_pkg
// Shared constants, codes and types of the voxel point histogram.
// ----------------------------------------------------------------------------
package pvh_pkg;

    // grid geometry
    localparam int unsigned GRID_SIZE  = 128;
    localparam int unsigned CELL_TOTAL = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int unsigned COORD_W    = $clog2(GRID_SIZE);
    localparam int unsigned ADDR_W     = $clog2(CELL_TOTAL);

    // field widths
    localparam int unsigned OP_W       = 2;
    localparam int unsigned RAW_W      = 32;
    localparam int unsigned INDEX_W    = 21;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned ORIGIN_W   = 34;
    localparam int unsigned GAIN_W     = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    // fixed-point datapath
    localparam int unsigned DIFF_W     = 35;
    localparam int unsigned MAG_W      = DIFF_W - 1;
    localparam int unsigned MAG_SPLIT  = 17;
    localparam int unsigned GAIN_SPLIT = 24;
    localparam int unsigned PP_W       = MAG_SPLIT + GAIN_SPLIT;
    localparam int unsigned PAIR_W     = MAG_SPLIT + GAIN_W;
    localparam int unsigned PROD_W     = MAG_W + GAIN_W;
    localparam int unsigned FRAC_W     = 40;
    localparam int unsigned Q_W        = PROD_W - FRAC_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input operation codes
    localparam logic [OP_W-1:0] OP_BIN        = 2'd0;
    localparam logic [OP_W-1:0] OP_READ       = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = 3'd5;

    // back-end command kinds
    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_NOP   = 2'd0;
    localparam cmd_kind_t CMD_BIN   = 2'd1;
    localparam cmd_kind_t CMD_READ  = 2'd2;
    localparam cmd_kind_t CMD_CLEAR = 2'd3;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [INDEX_W-1:0] index;
        logic               clamped;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/pvh_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_front
// Configuration registers, fixed-point binning pipeline and command build.
// ----------------------------------------------------------------------------
module pvh_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  accept,
    input  wire logic [pvh_pkg::OP_W-1:0]              operation,
    input  wire logic signed [pvh_pkg::RAW_W-1:0]      raw_x,
    input  wire logic signed [pvh_pkg::RAW_W-1:0]      raw_y,
    input  wire logic signed [pvh_pkg::RAW_W-1:0]      raw_z,
    input  wire logic [pvh_pkg::INDEX_W-1:0]           cell_address,
    input  wire logic                                  cfg_write,
    input  wire logic [pvh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [pvh_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  cmd_pop,
    output logic                                       credit_full,
    output logic                                       cmd_push,
    output pvh_pkg::cmd_t                              cmd
);

    typedef struct packed {
        logic [pvh_pkg::OP_W-1:0]    op;
        logic [pvh_pkg::INDEX_W-1:0] address;
        logic                        in_range;
    } meta_t;

    logic signed [pvh_pkg::ORIGIN_W-1:0] origin_reg [3];
    logic [pvh_pkg::GAIN_W-1:0]          gain_reg   [3];

    logic [4:0]                          vld_reg;
    meta_t                               meta_reg   [4];
    logic [pvh_pkg::QCNT_W-1:0]          inflight_reg;
    logic [pvh_pkg::QCNT_W-1:0]          inflight_next;

    logic signed [pvh_pkg::RAW_W-1:0]    raw_in     [3];
    logic signed [pvh_pkg::DIFF_W-1:0]   diff_reg   [3];
    logic                                neg2_reg   [3];
    logic [pvh_pkg::PP_W-1:0]            pp_ll_reg  [3];
    logic [pvh_pkg::PP_W-1:0]            pp_lh_reg  [3];
    logic [pvh_pkg::PP_W-1:0]            pp_hl_reg  [3];
    logic [pvh_pkg::PP_W-1:0]            pp_hh_reg  [3];
    logic                                neg3_reg   [3];
    logic [pvh_pkg::PAIR_W-1:0]          pair_a_reg [3];
    logic [pvh_pkg::PAIR_W-1:0]          pair_b_reg [3];
    logic [pvh_pkg::PROD_W-1:0]          total      [3];
    logic [pvh_pkg::Q_W-1:0]             quot       [3];
    logic [pvh_pkg::COORD_W-1:0]         coord_next [3];
    logic                                clamp_axis [3];
    logic [pvh_pkg::COORD_W-1:0]         coord_reg  [3];
    logic                                clamp_reg;
    logic [pvh_pkg::ADDR_W-1:0]          bin_addr;
    pvh_pkg::cmd_t                       cmd_next;
    pvh_pkg::cmd_t                       cmd_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                gain_reg[i]   <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pvh_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_data[pvh_pkg::ORIGIN_W-1:0];
                pvh_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_data[pvh_pkg::ORIGIN_W-1:0];
                pvh_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_data[pvh_pkg::ORIGIN_W-1:0];
                pvh_pkg::REG_GAIN_X:   gain_reg[0]   <= cfg_data[pvh_pkg::GAIN_W-1:0];
                pvh_pkg::REG_GAIN_Y:   gain_reg[1]   <= cfg_data[pvh_pkg::GAIN_W-1:0];
                pvh_pkg::REG_GAIN_Z:   gain_reg[2]   <= cfg_data[pvh_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // credit counter covers the pipeline and the command queue
    always_comb
    begin
        inflight_next = inflight_reg + pvh_pkg::QCNT_W'(accept)
                        - pvh_pkg::QCNT_W'(cmd_pop);
        credit_full   = (inflight_reg == pvh_pkg::QCNT_W'(pvh_pkg::QUEUE_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            vld_reg      <= {vld_reg[3:0], accept};
            inflight_reg <= inflight_next;
        end
    end

    always_comb
    begin
        raw_in[0] = raw_x;
        raw_in[1] = raw_y;
        raw_in[2] = raw_z;
    end

    // stage 1: offset from the cube corner
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_reg[i] <= pvh_pkg::DIFF_W'(raw_in[i]) - pvh_pkg::DIFF_W'(origin_reg[i]);
        end
        meta_reg[0].op       <= operation;
        meta_reg[0].address  <= cell_address;
        meta_reg[0].in_range <= (64'(cell_address) < 64'(pvh_pkg::CELL_TOTAL));
        for (int s = 1; s < 4; s++)
        begin
            meta_reg[s] <= meta_reg[s-1];
        end
    end

    // stage 2: four partial products of magnitude times gain
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg2_reg[i]  <= diff_reg[i][pvh_pkg::DIFF_W-1];
            pp_ll_reg[i] <=
                pvh_pkg::PP_W'(diff_reg[i][pvh_pkg::MAG_SPLIT-1:0])
                * pvh_pkg::PP_W'(gain_reg[i][pvh_pkg::GAIN_SPLIT-1:0]);
            pp_lh_reg[i] <=
                pvh_pkg::PP_W'(diff_reg[i][pvh_pkg::MAG_SPLIT-1:0])
                * pvh_pkg::PP_W'(gain_reg[i][pvh_pkg::GAIN_W-1:pvh_pkg::GAIN_SPLIT]);
            pp_hl_reg[i] <=
                pvh_pkg::PP_W'(diff_reg[i][pvh_pkg::MAG_W-1:pvh_pkg::MAG_SPLIT])
                * pvh_pkg::PP_W'(gain_reg[i][pvh_pkg::GAIN_SPLIT-1:0]);
            pp_hh_reg[i] <=
                pvh_pkg::PP_W'(diff_reg[i][pvh_pkg::MAG_W-1:pvh_pkg::MAG_SPLIT])
                * pvh_pkg::PP_W'(gain_reg[i][pvh_pkg::GAIN_W-1:pvh_pkg::GAIN_SPLIT]);
        end
    end

    // stage 3: combine along the gain split
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg3_reg[i]   <= neg2_reg[i];
            pair_a_reg[i] <= pvh_pkg::PAIR_W'(pp_ll_reg[i])
                             + (pvh_pkg::PAIR_W'(pp_lh_reg[i]) << pvh_pkg::GAIN_SPLIT);
            pair_b_reg[i] <= pvh_pkg::PAIR_W'(pp_hl_reg[i])
                             + (pvh_pkg::PAIR_W'(pp_hh_reg[i]) << pvh_pkg::GAIN_SPLIT);
        end
    end

    // stage 4: full product, drop the fraction, saturate into the grid
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            total[i] = pvh_pkg::PROD_W'(pair_a_reg[i])
                       + (pvh_pkg::PROD_W'(pair_b_reg[i]) << pvh_pkg::MAG_SPLIT);
            quot[i]  = total[i][pvh_pkg::PROD_W-1:pvh_pkg::FRAC_W];
            if (neg3_reg[i])
            begin
                coord_next[i] = '0;
                clamp_axis[i] = 1'b1;
            end
            else if (quot[i] > pvh_pkg::Q_W'(pvh_pkg::GRID_SIZE - 1))
            begin
                coord_next[i] = pvh_pkg::COORD_W'(pvh_pkg::GRID_SIZE - 1);
                clamp_axis[i] = 1'b1;
            end
            else
            begin
                coord_next[i] = quot[i][pvh_pkg::COORD_W-1:0];
                clamp_axis[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            coord_reg[i] <= coord_next[i];
        end
        clamp_reg <= clamp_axis[0] | clamp_axis[1] | clamp_axis[2];
    end

    // stage 5: linear cell address and command classification
    always_comb
    begin
        bin_addr = pvh_pkg::ADDR_W'(coord_reg[0])
                   + pvh_pkg::ADDR_W'(coord_reg[1]) * pvh_pkg::ADDR_W'(pvh_pkg::GRID_SIZE)
                   + pvh_pkg::ADDR_W'(coord_reg[2])
                     * pvh_pkg::ADDR_W'(pvh_pkg::GRID_SIZE * pvh_pkg::GRID_SIZE);
        cmd_next = '0;
        unique case (meta_reg[3].op)
            pvh_pkg::OP_BIN:
            begin
                cmd_next.kind    = pvh_pkg::CMD_BIN;
                cmd_next.addr    = bin_addr;
                cmd_next.index   = pvh_pkg::INDEX_W'(bin_addr);
                cmd_next.clamped = clamp_reg;
            end
            pvh_pkg::OP_READ, pvh_pkg::OP_READ_CLEAR:
            begin
                if (!meta_reg[3].in_range)
                begin
                    cmd_next.kind = pvh_pkg::CMD_NOP;
                end
                else if (meta_reg[3].op == pvh_pkg::OP_READ_CLEAR)
                begin
                    cmd_next.kind = pvh_pkg::CMD_CLEAR;
                end
                else
                begin
                    cmd_next.kind = pvh_pkg::CMD_READ;
                end
                cmd_next.addr  = pvh_pkg::ADDR_W'(meta_reg[3].address);
                cmd_next.index = meta_reg[3].address;
            end
            default:
            begin
                cmd_next.kind = pvh_pkg::CMD_NOP;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_push = vld_reg[4];
    assign cmd      = cmd_reg;

endmodule
`default_nettype wire

@@ rtl/pvh_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_queue
// Short command queue that decouples the binning front from the count store.
// ----------------------------------------------------------------------------
module pvh_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pvh_pkg::cmd_t din,
    input  wire logic          pop,
    output pvh_pkg::cmd_t      dout,
    output logic               empty
);

    pvh_pkg::cmd_t                entries [pvh_pkg::QUEUE_DEPTH];
    logic [pvh_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [pvh_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [pvh_pkg::QCNT_W-1:0]   cnt_reg;
    logic [pvh_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [pvh_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [pvh_pkg::QCNT_W-1:0]   cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pvh_pkg::QPTR_W'(pvh_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pvh_pkg::QPTR_W'(pvh_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + pvh_pkg::QCNT_W'(push) - pvh_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= din;
        end
    end

    assign dout  = entries[rd_ptr_reg];
    assign empty = (cnt_reg == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (cnt_reg != pvh_pkg::QCNT_W'(pvh_pkg::QUEUE_DEPTH)))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("command queue popped while empty");
`endif

endmodule
`default_nettype wire

@@ rtl/pvh_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_back
// Count store with clearing pass, read-modify-write with forwarding, and
// the result register.
// ----------------------------------------------------------------------------
module pvh_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    input  wire pvh_pkg::cmd_t                   q_head,
    output logic                                 q_pop,
    output logic                                 clearing,
    input  wire logic                            pop,
    output logic                                 empty,
    output logic [pvh_pkg::INDEX_W-1:0]          cell_index,
    output logic [pvh_pkg::COUNT_W-1:0]          count,
    output logic                                 clamped
);

    logic [pvh_pkg::COUNT_W-1:0]  count_mem [pvh_pkg::CELL_TOTAL];

    logic                         clearing_reg;
    logic [pvh_pkg::ADDR_W-1:0]   clr_cnt_reg;

    logic                         s1_valid_reg;
    pvh_pkg::cmd_t                s1_cmd_reg;
    logic [pvh_pkg::COUNT_W-1:0]  rdata_reg;

    logic                         fwd_valid_reg;
    logic [pvh_pkg::ADDR_W-1:0]   fwd_addr_reg;
    logic [pvh_pkg::COUNT_W-1:0]  fwd_data_reg;

    logic                         out_valid_reg;
    logic [pvh_pkg::INDEX_W-1:0]  out_index_reg;
    logic [pvh_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         out_clamped_reg;

    logic                         out_ready;
    logic                         s1_adv;
    logic                         take;
    logic [pvh_pkg::COUNT_W-1:0]  cur;
    logic [pvh_pkg::COUNT_W-1:0]  new_count;
    logic [pvh_pkg::COUNT_W-1:0]  res_count;
    logic                         wr_en;
    logic                         s1_write;

    always_comb
    begin
        out_ready = !out_valid_reg || pop;
        s1_adv    = !s1_valid_reg || out_ready;
        take      = s1_adv && !q_empty && !clearing_reg;
        // the write made in the cycle of our read is not yet in the read data
        cur       = (fwd_valid_reg && (fwd_addr_reg == s1_cmd_reg.addr))
                    ? fwd_data_reg : rdata_reg;
        new_count = (cur == pvh_pkg::COUNT_MAX) ? cur : cur + 1'b1;
        res_count = '0;
        wr_en     = 1'b0;
        case (s1_cmd_reg.kind)
            pvh_pkg::CMD_BIN:
            begin
                res_count = new_count;
                wr_en     = 1'b1;
            end
            pvh_pkg::CMD_READ:
            begin
                res_count = cur;
            end
            pvh_pkg::CMD_CLEAR:
            begin
                res_count = cur;
                wr_en     = 1'b1;
            end
            default:
            begin
                res_count = '0;
            end
        endcase
        s1_write = s1_valid_reg && out_ready && wr_en;
    end

    // clearing pass over the whole store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == pvh_pkg::ADDR_W'(pvh_pkg::CELL_TOTAL - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            count_mem[clr_cnt_reg] <= '0;
        end
        else if (s1_write)
        begin
            count_mem[s1_cmd_reg.addr] <= (s1_cmd_reg.kind == pvh_pkg::CMD_BIN)
                                          ? new_count : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rdata_reg <= count_mem[q_head.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg  <= take;
                fwd_valid_reg <= s1_valid_reg && wr_en;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg <= q_head;
        end
        if (s1_adv)
        begin
            fwd_addr_reg <= s1_cmd_reg.addr;
            fwd_data_reg <= (s1_cmd_reg.kind == pvh_pkg::CMD_BIN) ? new_count : '0;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_index_reg   <= s1_cmd_reg.index;
            out_count_reg   <= res_count;
            out_clamped_reg <= s1_cmd_reg.clamped;
        end
    end

    assign q_pop      = take;
    assign clearing   = clearing_reg;
    assign empty      = !out_valid_reg;
    assign cell_index = out_index_reg;
    assign count      = out_count_reg;
    assign clamped    = out_clamped_reg;

`ifndef SYNTHESIS
    a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !take && !out_valid_reg))
        else $error("count store used during clearing pass");

    a_bin_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_cmd_reg.kind == pvh_pkg::CMD_BIN)) |-> (new_count != '0))
        else $error("binned cell count is zero");
`endif

endmodule
`default_nettype wire

@@ rtl/point_voxel_histogram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// point_voxel_histogram
// Bins points into a cubic voxel grid and keeps a saturating count per cell;
// cells can be read, or read and cleared.
// ----------------------------------------------------------------------------
// path: five front stages, one queue slot, one store read, one result register
// throughput: one item per cycle while full is low and results are popped;
//   the count store has one read and one write port per cycle, and a one-deep
//   bypass covers back-to-back hits on a cell
// reset: control registers clear at once, then a clearing pass writes zero to
//   every cell with full held high
// ----------------------------------------------------------------------------
module point_voxel_histogram (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic [pvh_pkg::OP_W-1:0]              operation,
    input  wire logic signed [pvh_pkg::RAW_W-1:0]      raw_x,
    input  wire logic signed [pvh_pkg::RAW_W-1:0]      raw_y,
    input  wire logic signed [pvh_pkg::RAW_W-1:0]      raw_z,
    input  wire logic [pvh_pkg::INDEX_W-1:0]           cell_address,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic [pvh_pkg::INDEX_W-1:0]                cell_index,
    output logic [pvh_pkg::COUNT_W-1:0]                count,
    output logic                                       clamped,
    input  wire logic                                  cfg_write,
    input  wire logic [pvh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [pvh_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic          accept;
    logic          credit_full;
    logic          clearing;
    logic          cmd_push;
    pvh_pkg::cmd_t cmd;
    logic          q_pop;
    logic          q_empty;
    pvh_pkg::cmd_t q_head;

    assign full   = credit_full | clearing;
    assign accept = push & !full;

    pvh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .raw_z        (raw_z),
        .cell_address (cell_address),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_pop      (q_pop),
        .credit_full  (credit_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    pvh_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    pvh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .pop        (pop),
        .empty      (empty),
        .cell_index (cell_index),
        .count      (count),
        .clamped    (clamped)
    );

endmodule
`default_nettype wire
